/* hdl/rrnt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrnt_pkg
// Shared constants, codes and types of the reliable reader nack tracker.
// ----------------------------------------------------------------------------
package rrnt_pkg;

  localparam int unsigned WRITERS    = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned WINDOW     = 64;
  localparam int unsigned IDX_W      = $clog2(WINDOW);
  localparam int unsigned MAX_NACK   = 8;
  localparam int unsigned LIM_W      = 4;
  localparam int unsigned SEQ_W      = 64;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned INTERVAL_W = 16;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd500;
  localparam logic [LIM_W-1:0]      MAXSEQ_RST   = 4'd8;

  // register index, taken from paddr[2]
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_MAXSEQ   = 1'b1;

  // message kinds
  localparam logic MODE_DATA      = 1'b0;
  localparam logic MODE_HEARTBEAT = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIFF,
    CMD_APPLY,
    CMD_SHIFT,
    CMD_WRAP,
    CMD_RATE,
    CMD_WRITE,
    CMD_SCAN
  } cmd_op_e;

  typedef struct packed {
    logic    in_load;
    cmd_op_e op;
  } cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic shift_go;
    logic rcv0;
    logic run_ok;
    logic scan_done;
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  last;
    logic [SEQ_W-1:0]  first;
    logic [SEQ_W-1:0]  seq;
    logic [ID_W-1:0]   rid;
    logic [ID_W-1:0]   wid;
    logic [SLOT_W-1:0] slot;
    logic              mode;
  } item_t;

  typedef struct packed {
    logic               last_in_run;
    logic [STAMP_W-1:0] stamp;
    logic [SEQ_W-1:0]   missing;
    logic [PORT_W-1:0]  port;
    logic [ADDR_W-1:0]  addr;
    logic [ID_W-1:0]    rid;
    logic [ID_W-1:0]    wid;
  } res_t;

endpackage
`default_nettype wire

/* hdl/rrnt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrnt_ctrl
// Sequencer: steps one message through load, compare, update, write back
// and the scan that emits the acknowledgement run.
// ----------------------------------------------------------------------------
module rrnt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rrnt_pkg::status_t status_i,
  output rrnt_pkg::cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DIFF, ST_APPLY, ST_SHIFT, ST_WRAP, ST_RATE, ST_WRITE, ST_SCAN
  } state_e;

  state_e state_q;

  assign in_ready_o     = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.in_load = in_valid_i && (state_q == ST_IDLE);
    case (state_q)
      ST_LOAD:  cmd_o.op = rrnt_pkg::CMD_LOAD;
      ST_DIFF:  cmd_o.op = rrnt_pkg::CMD_DIFF;
      ST_APPLY: cmd_o.op = rrnt_pkg::CMD_APPLY;
      ST_SHIFT: cmd_o.op = rrnt_pkg::CMD_SHIFT;
      ST_WRAP:  cmd_o.op = rrnt_pkg::CMD_WRAP;
      ST_RATE:  cmd_o.op = rrnt_pkg::CMD_RATE;
      ST_WRITE: cmd_o.op = rrnt_pkg::CMD_WRITE;
      ST_SCAN:  cmd_o.op = rrnt_pkg::CMD_SCAN;
      default:  cmd_o.op = rrnt_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE:  if (in_valid_i) state_q <= ST_LOAD;
        ST_LOAD:  state_q <= status_i.slot_ok ? ST_DIFF : ST_IDLE;
        ST_DIFF:  state_q <= ST_APPLY;
        ST_APPLY: state_q <= status_i.shift_go ? ST_SHIFT : ST_RATE;
        ST_SHIFT: if (!status_i.rcv0) state_q <= ST_WRAP;
        ST_WRAP:  state_q <= ST_RATE;
        ST_RATE:  state_q <= ST_WRITE;
        ST_WRITE: state_q <= status_i.run_ok ? ST_SCAN : ST_IDLE;
        ST_SCAN:  if (status_i.scan_done) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/rrnt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrnt_dp
// Datapath: per-writer table, working copy of one entry, window updates,
// rate check, bit scan and the output register.
// ----------------------------------------------------------------------------
module rrnt_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rrnt_pkg::item_t                     item_i,
  input  wire rrnt_pkg::cmd_t                      cmd_i,
  output rrnt_pkg::status_t                        status_o,
  input  wire logic [rrnt_pkg::INTERVAL_W-1:0]     interval_i,
  input  wire logic [rrnt_pkg::LIM_W-1:0]          maxseq_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output rrnt_pkg::res_t                           out_o
);

  localparam int unsigned W = rrnt_pkg::WINDOW;

  // per-writer table; a slot whose valid bit is clear reads as all zeros
  logic [rrnt_pkg::WRITERS-1:0] vld_q;
  logic [rrnt_pkg::SEQ_W-1:0]   exp_mem  [rrnt_pkg::WRITERS];
  logic [W-1:0]                 rcv_mem  [rrnt_pkg::WRITERS];
  logic [W-1:0]                 miss_mem [rrnt_pkg::WRITERS];
  logic [rrnt_pkg::TIME_W-1:0]  last_mem [rrnt_pkg::WRITERS];
  logic [rrnt_pkg::ID_W-1:0]    rdr_mem  [rrnt_pkg::WRITERS];

  rrnt_pkg::item_t              item_q;
  logic [rrnt_pkg::SEQ_W-1:0]   w_exp_q;
  logic [W-1:0]                 w_rcv_q, w_miss_q;
  logic [rrnt_pkg::TIME_W-1:0]  w_last_q;
  logic [rrnt_pkg::ID_W-1:0]    w_rdr_q;
  logic [rrnt_pkg::ADDR_W-1:0]  w_addr_q;
  logic [rrnt_pkg::PORT_W-1:0]  w_port_q;

  logic                         skip_q, run_en_q, eq_q, gt_q, big_q, rate_ok_q;
  logic [rrnt_pkg::IDX_W-1:0]   d_idx_q;
  logic [W-1:0]                 sc_word_q;
  logic [rrnt_pkg::IDX_W-1:0]   sc_idx_q;
  logic [rrnt_pkg::LIM_W-1:0]   sc_cnt_q, lim_q;
  logic                         out_valid_q;
  rrnt_pkg::res_t               out_q;

  logic                         rd_vld;
  logic [rrnt_pkg::SEQ_W-1:0]   rd_exp, src, dif;
  logic [rrnt_pkg::TIME_W-1:0]  age;
  logic [W-1:0]                 bitd, below;
  logic [rrnt_pkg::LIM_W-1:0]   lim;
  logic                         adv, emit, fin;

  assign rd_vld = vld_q[item_q.slot];
  assign rd_exp = rd_vld ? exp_mem[item_q.slot] : '0;
  assign src    = (item_q.mode == rrnt_pkg::MODE_HEARTBEAT) ? item_q.last : item_q.seq;
  assign dif    = src - w_exp_q;
  assign age    = item_q.now - w_last_q;
  assign bitd   = W'(1) << d_idx_q;
  assign below  = bitd - W'(1);

  always_comb begin
    if (maxseq_i == '0) begin
      lim = rrnt_pkg::LIM_W'(1);
    end else if (maxseq_i > rrnt_pkg::LIM_W'(rrnt_pkg::MAX_NACK)) begin
      lim = rrnt_pkg::LIM_W'(rrnt_pkg::MAX_NACK);
    end else begin
      lim = maxseq_i;
    end
  end

  assign adv  = !out_valid_q || out_ready_i;
  assign emit = (cmd_i.op == rrnt_pkg::CMD_SCAN) && adv && sc_word_q[0];
  assign fin  = emit && ((sc_cnt_q + rrnt_pkg::LIM_W'(1)) == lim_q ||
                         sc_word_q[W-1:1] == '0);

  assign status_o.slot_ok   = ({1'b0, item_q.slot} <
                               (rrnt_pkg::SLOT_W + 1)'(rrnt_pkg::WRITERS));
  assign status_o.shift_go  = run_en_q && eq_q && (item_q.mode == rrnt_pkg::MODE_DATA);
  assign status_o.rcv0      = w_rcv_q[0];
  assign status_o.run_ok    = rate_ok_q;
  assign status_o.scan_done = fin;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == rrnt_pkg::CMD_WRITE) vld_q[item_q.slot] <= 1'b1;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) item_q <= item_i;
    case (cmd_i.op)
      rrnt_pkg::CMD_LOAD: begin
        w_addr_q <= item_q.addr;
        w_port_q <= item_q.port;
        w_last_q <= rd_vld ? last_mem[item_q.slot] : '0;
        w_rdr_q  <= (item_q.mode == rrnt_pkg::MODE_DATA) ? item_q.rid :
                    (rd_vld ? rdr_mem[item_q.slot] : '0);
        skip_q   <= 1'b0;
        if (item_q.mode == rrnt_pkg::MODE_DATA && rd_exp == '0) begin
          w_exp_q  <= item_q.seq + rrnt_pkg::SEQ_W'(1);
          w_rcv_q  <= '0;
          w_miss_q <= '0;
          skip_q   <= 1'b1;
        end else if (item_q.mode == rrnt_pkg::MODE_HEARTBEAT && rd_exp == '0 &&
                     item_q.first != '0) begin
          w_exp_q  <= item_q.first;
          w_rcv_q  <= '0;
          w_miss_q <= '0;
        end else begin
          w_exp_q  <= rd_exp;
          w_rcv_q  <= rd_vld ? rcv_mem[item_q.slot] : '0;
          w_miss_q <= rd_vld ? miss_mem[item_q.slot] : '0;
        end
      end
      rrnt_pkg::CMD_DIFF: begin
        eq_q     <= (src == w_exp_q);
        gt_q     <= (src > w_exp_q);
        big_q    <= (dif >= rrnt_pkg::SEQ_W'(W));
        d_idx_q  <= (dif >= rrnt_pkg::SEQ_W'(W)) ? rrnt_pkg::IDX_W'(W - 1) :
                    dif[rrnt_pkg::IDX_W-1:0];
        run_en_q <= !skip_q && ((item_q.mode == rrnt_pkg::MODE_DATA) ||
                    (w_exp_q != '0 && src >= w_exp_q));
      end
      rrnt_pkg::CMD_APPLY: begin
        if (run_en_q) begin
          if (item_q.mode == rrnt_pkg::MODE_HEARTBEAT) begin
            w_miss_q <= w_miss_q | ((below | bitd) & ~w_rcv_q);
          end else if (eq_q) begin
            w_rcv_q <= w_rcv_q | W'(1);
          end else if (gt_q && big_q) begin
            w_miss_q <= w_miss_q | ~w_rcv_q;
          end else if (gt_q) begin
            w_miss_q <= (w_miss_q | (below & ~w_rcv_q)) & ~bitd;
            w_rcv_q  <= w_rcv_q | bitd;
          end
        end
      end
      rrnt_pkg::CMD_SHIFT: begin
        // slide the window past one received number
        if (w_rcv_q[0]) begin
          w_rcv_q  <= w_rcv_q >> 1;
          w_miss_q <= w_miss_q >> 1;
          w_exp_q  <= w_exp_q + rrnt_pkg::SEQ_W'(1);
        end
      end
      rrnt_pkg::CMD_WRAP: begin
        if (w_exp_q == '0) begin
          w_rcv_q  <= '0;
          w_miss_q <= '0;
        end
      end
      rrnt_pkg::CMD_RATE: begin
        rate_ok_q <= run_en_q && (w_miss_q != '0) && (item_q.now >= w_last_q) &&
                     (age >= rrnt_pkg::TIME_W'(interval_i));
        if (run_en_q && (w_miss_q != '0) && (item_q.now >= w_last_q) &&
            (age >= rrnt_pkg::TIME_W'(interval_i))) begin
          w_last_q <= item_q.now;
        end
        sc_word_q <= w_miss_q;
        sc_idx_q  <= '0;
        sc_cnt_q  <= '0;
        lim_q     <= lim;
      end
      rrnt_pkg::CMD_WRITE: begin
        exp_mem[item_q.slot]  <= w_exp_q;
        rcv_mem[item_q.slot]  <= w_rcv_q;
        miss_mem[item_q.slot] <= w_miss_q;
        last_mem[item_q.slot] <= w_last_q;
        rdr_mem[item_q.slot]  <= w_rdr_q;
      end
      rrnt_pkg::CMD_SCAN: begin
        if (adv) begin
          sc_word_q <= sc_word_q >> 1;
          sc_idx_q  <= sc_idx_q + rrnt_pkg::IDX_W'(1);
          if (emit) sc_cnt_q <= sc_cnt_q + rrnt_pkg::LIM_W'(1);
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_q.wid         <= item_q.wid;
      out_q.rid         <= w_rdr_q;
      out_q.addr        <= w_addr_q;
      out_q.port        <= w_port_q;
      out_q.missing     <= w_exp_q + rrnt_pkg::SEQ_W'(sc_idx_q);
      out_q.stamp       <= item_q.now[rrnt_pkg::STAMP_W-1:0];
      out_q.last_in_run <= fin;
    end
  end

`ifndef SYNTH
  a_scan_word_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rrnt_pkg::CMD_SCAN |-> sc_word_q != '0)
    else $error("scan running over an empty missing window");
  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rrnt_pkg::CMD_SCAN |-> sc_cnt_q < lim_q)
    else $error("run longer than its limit");
  a_rate_needs_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rrnt_pkg::CMD_RATE |=> (!rate_ok_q || w_miss_q != '0))
    else $error("run granted with nothing missing");
`endif

endmodule
`default_nettype wire

/* hdl/reliable_reader_nack_tracker_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// reliable_reader_nack_tracker_core
// Reliable reader negative acknowledgement tracker with APB configuration.
// ----------------------------------------------------------------------------
// Takes one data or heartbeat message per input transfer and updates the
// receive and missing windows of that writer slot. A message steps through
// table read, compare, window update, rate check and write back; a data
// message that fills the gap at its head also slides the window past each
// received number there (up to 64 numbers) and then checks for wrap, and a
// granted run adds a scan of the window bits up to the last number reported,
// which stalls whenever the output register is still held by the sink. The
// window slide and the bit scan run one bit per cycle on separate shifters,
// the scan only while the output register is free; the next message is
// taken once the run has been handed to the output register. Each reported
// number is one output transfer; tlast marks the final number of a run.
// Registers: 0x0 minimum interval in ms (reset 500), 0x4 run length limit
// (reset 8; 0 acts as 1). No clearing pass: the table resets at once.
module reliable_reader_nack_tracker_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // tdata: writer_slot, writer_ident, reader_ident, seq_num, first_seq,
  //        last_seq, sender_addr, sender_port, now_ms, zero pad (360 bits)
  input  wire logic [359:0] s_axis_tdata,
  // tuser: mode
  input  wire logic         s_axis_tuser,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: out_writer_ident, out_reader_ident, dest_addr, dest_port,
  //        missing_seq, nack_stamp (208 bits)
  output logic [207:0]      m_axis_tdata,
  output logic              m_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [rrnt_pkg::INTERVAL_W-1:0] interval_q;
  logic [rrnt_pkg::LIM_W-1:0]      maxseq_q;
  rrnt_pkg::item_t                 item;
  rrnt_pkg::cmd_t                  cmd;
  rrnt_pkg::status_t               status;
  rrnt_pkg::res_t                  res;

  // configuration: write on the access cycle, read data by address
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rrnt_pkg::REG_MAXSEQ) ? {28'b0, maxseq_q} :
                                                        {16'b0, interval_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= rrnt_pkg::INTERVAL_RST;
      maxseq_q   <= rrnt_pkg::MAXSEQ_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == rrnt_pkg::REG_INTERVAL) begin
        interval_q <= pwdata[rrnt_pkg::INTERVAL_W-1:0];
      end else begin
        maxseq_q <= pwdata[rrnt_pkg::LIM_W-1:0];
      end
    end
  end

  // unpack the input transfer
  assign item.mode  = s_axis_tuser;
  assign item.slot  = s_axis_tdata[3:0];
  assign item.wid   = s_axis_tdata[35:4];
  assign item.rid   = s_axis_tdata[67:36];
  assign item.seq   = s_axis_tdata[131:68];
  assign item.first = s_axis_tdata[195:132];
  assign item.last  = s_axis_tdata[259:196];
  assign item.addr  = s_axis_tdata[291:260];
  assign item.port  = s_axis_tdata[307:292];
  assign item.now   = s_axis_tdata[355:308];

  rrnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrnt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .interval_i  (interval_q),
    .maxseq_i    (maxseq_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // pack the result transfer
  assign m_axis_tdata = {res.stamp, res.missing, res.port, res.addr, res.rid, res.wid};
  assign m_axis_tlast = res.last_in_run;

endmodule
`default_nettype wire
